FILE: rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// Date-time difference package
// Shared beat types, widths and calendar constants for the date-time
// difference pipeline.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Field widths of one date-time.
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  // Internal widths: day count since year zero, seconds within a day, linear
  // seconds and the delivered duration.
  localparam int unsigned DaysW = 23;
  localparam int unsigned TodW  = 17;
  localparam int unsigned SecW  = 40;
  localparam int unsigned DurW  = 39;

  // Division by 100 is a multiply by ceil(2^22 / 100) and a shift by 22. The
  // result is exact for every dividend below 2^15.
  localparam logic [15:0] RecipK     = 16'd41944;
  localparam int unsigned RecipShift = 22;

  localparam logic [TodW-1:0] SecsPerDay  = 17'd86400;
  localparam logic [TodW-1:0] SecsPerHour = 17'd3600;
  localparam logic [TodW-1:0] SecsPerMin  = 17'd60;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
  } dds_time_t;

  typedef struct packed {
    logic [YearW-1:0]   start_year;
    logic [MonthW-1:0]  start_month;
    logic [DayW-1:0]    start_day;
    logic [HourW-1:0]   start_hour;
    logic [MinuteW-1:0] start_minute;
    logic [SecondW-1:0] start_second;
    logic [YearW-1:0]   end_year;
    logic [MonthW-1:0]  end_month;
    logic [DayW-1:0]    end_day;
    logic [HourW-1:0]   end_hour;
    logic [MinuteW-1:0] end_minute;
    logic [SecondW-1:0] end_second;
  } dds_in_t;

  typedef struct packed {
    logic [DurW-1:0] duration_seconds;
    logic            start_is_later;
  } dds_out_t;

  // Load enables of the three conversion stages.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } dds_stage_en_t;

  // Days before the first of a month in a common year. Month zero counts as
  // January, months past December as the day after the year ends.
  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
    logic [8:0] days;
    case (month)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd365;
    endcase
    return days;
  endfunction

endpackage

FILE: rtl/dds_linear.sv
// ----------------------------------------------------------------------------
// Date-time to linear seconds
// Three-stage conversion of one date-time into seconds since year zero.
// ----------------------------------------------------------------------------
module dds_linear (
  input  logic                        clk_i,
  input  dds_pkg::dds_stage_en_t      en_i,
  input  dds_pkg::dds_time_t          time_i,
  output logic [dds_pkg::SecW-1:0]    secs_o
);

  // Stage A: reciprocal products for the century counts, time of day.
  logic [14:0] y99, y399;
  logic [30:0] prod100_d, prod100_q;
  logic [28:0] prod400_d, prod400_q;
  logic [dds_pkg::TodW-1:0] tod_d, tod_a_q, tod_b_q;
  logic [dds_pkg::YearW-1:0]  year_a_q;
  logic [dds_pkg::MonthW-1:0] month_a_q;
  logic [dds_pkg::DayW-1:0]   day_a_q;

  assign y99  = {1'b0, time_i.year} + 15'd99;
  assign y399 = {1'b0, time_i.year} + 15'd399;
  assign prod100_d = 31'(y99) * 31'(dds_pkg::RecipK);
  assign prod400_d = 29'(y399[14:2]) * 29'(dds_pkg::RecipK);
  assign tod_d = 17'(time_i.hour) * dds_pkg::SecsPerHour
               + 17'(time_i.minute) * dds_pkg::SecsPerMin
               + 17'(time_i.second);

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      prod100_q <= prod100_d;
      prod400_q <= prod400_d;
      tod_a_q   <= tod_d;
      year_a_q  <= time_i.year;
      month_a_q <= time_i.month;
      day_a_q   <= time_i.day;
    end
  end

  // Stage B: day count since the start of year zero.
  logic [7:0]  c100;
  logic [5:0]  c400;
  logic [14:0] y3;
  logic        div100, div400, leap, leap_adj;
  logic [23:0] days_sum;
  logic [dds_pkg::DaysW-1:0] days_d, days_q;

  assign c100   = prod100_q[dds_pkg::RecipShift+7:dds_pkg::RecipShift];
  assign c400   = prod400_q[dds_pkg::RecipShift+5:dds_pkg::RecipShift];
  assign div100 = (15'(c100) * 15'd100) == {1'b0, year_a_q};
  assign div400 = (15'(c400) * 15'd400) == {1'b0, year_a_q};
  assign leap   = ((year_a_q[1:0] == 2'b00) && !div100) || div400;
  assign leap_adj = leap && (month_a_q > 4'd2);
  assign y3     = {1'b0, year_a_q} + 15'd3;

  assign days_sum = 24'(year_a_q) * 24'd365 + 24'(y3[14:2]) - 24'(c100) + 24'(c400)
                  + 24'(dds_pkg::days_before_month(month_a_q)) + 24'(leap_adj)
                  + 24'(day_a_q);
  assign days_d = days_sum[dds_pkg::DaysW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      days_q  <= days_d;
      tod_b_q <= tod_a_q;
    end
  end

  // Stage C: scale days to seconds and add the time of day.
  logic [dds_pkg::SecW-1:0] secs_d, secs_q;

  assign secs_d = 40'(days_q) * 40'(dds_pkg::SecsPerDay) + 40'(tod_b_q);

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      secs_q <= secs_d;
    end
  end

  assign secs_o = secs_q;

endmodule

FILE: rtl/dds_compare.sv
// ----------------------------------------------------------------------------
// Linear time compare
// Compares two linear times and registers the clamped difference.
// ----------------------------------------------------------------------------
module dds_compare (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [dds_pkg::SecW-1:0] t0_i,
  input  logic [dds_pkg::SecW-1:0] t1_i,
  output dds_pkg::dds_out_t        result_o,
  output logic                     done_o
);

  logic                     later;
  logic [dds_pkg::SecW-1:0] diff;
  dds_pkg::dds_out_t        result_d, result_q;
  logic                     done_q;

  assign later = t0_i > t1_i;
  assign diff  = t1_i - t0_i;

  always_comb begin
    result_d.start_is_later   = later;
    result_d.duration_seconds = later ? '0 : diff[dds_pkg::DurW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

FILE: rtl/datetime_difference_seconds_top.sv
// ----------------------------------------------------------------------------
// Date-time difference in seconds
// Pipelined Gregorian date-time difference, one beat per clock.
// ----------------------------------------------------------------------------
// Usage: drive a start/end date-time pair on item_i and raise start for one
// cycle; the beat is taken at the rising edge where start is high and busy
// is low. busy stays low, so a new beat may be presented in every cycle.
// Each beat yields exactly one result beat on result_o, marked by done_o for
// a single cycle, once it has passed stages A, B, C and the compare. The result
// carries the seconds from start to end, or zero with start_is_later set when
// the start lies after the end. Equal times give zero with the flag clear.
// Throughput is one beat per cycle. The result is registered in turn by the
// conversion pipeline: reciprocal multiplies for the century counts, the day
// count, the scale to seconds, and the final compare and subtract.
// The receiver cannot hold results off; every result is shown exactly once.
// Reset clears the valid bits of all stages, so beats in flight at reset are
// dropped and no stale result appears afterward.
module datetime_difference_seconds_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dds_pkg::dds_in_t  item_i,
  output dds_pkg::dds_out_t result_o,
  output logic              done_o
);

  logic                   accept;
  logic                   va_q, vb_q, vc_q;
  dds_pkg::dds_stage_en_t en;
  dds_pkg::dds_time_t     t_start, t_end;
  logic [dds_pkg::SecW-1:0] secs0, secs1;

  // The pipeline never stalls, so the block is always ready for a beat.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits travel alongside the payload and gate each stage's load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= accept;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign en.a = accept;
  assign en.b = va_q;
  assign en.c = vb_q;

  always_comb begin
    t_start.year   = item_i.start_year;
    t_start.month  = item_i.start_month;
    t_start.day    = item_i.start_day;
    t_start.hour   = item_i.start_hour;
    t_start.minute = item_i.start_minute;
    t_start.second = item_i.start_second;
    t_end.year     = item_i.end_year;
    t_end.month    = item_i.end_month;
    t_end.day      = item_i.end_day;
    t_end.hour     = item_i.end_hour;
    t_end.minute   = item_i.end_minute;
    t_end.second   = item_i.end_second;
  end

  // Both times are converted in parallel by identical pipelines.
  dds_linear u_linear_start (
    .clk_i  (clk_i),
    .en_i   (en),
    .time_i (t_start),
    .secs_o (secs0)
  );

  dds_linear u_linear_end (
    .clk_i  (clk_i),
    .en_i   (en),
    .time_i (t_end),
    .secs_o (secs1)
  );

  dds_compare u_compare (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vc_q),
    .t0_i     (secs0),
    .t1_i     (secs1),
    .result_o (result_o),
    .done_o   (done_o)
  );

  // A later start always reports a zero duration.
  a_later_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.start_is_later |-> result_o.duration_seconds == '0)
    else $error("later start reported a nonzero duration");

  // Every accepted beat produces its result after the full pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted beat produced no result");

  // No result appears without a matching earlier accepted beat.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without a matching accepted beat");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-time difference testbench
// Drives start/end date-time pairs into the pipeline and checks every result
// beat against an independent calendar computation. The run has a short
// directed set, then three random phases with different sender gap rates.
// ----------------------------------------------------------------------------
module testbench;

  // No accepted beat and no result for this many cycles ends the run. The
  // longest legitimate quiet stretch is a random sender gap or a drain of the
  // four-stage pipeline, both far below this.
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandomPerPhase = 180;
  localparam int unsigned TimeW = $bits(dds_pkg::dds_time_t);

  // Days before the first of each month in a common year, indexed by the
  // raw 4-bit month. Month zero behaves as January, and months past December
  // sit one full year in.
  localparam int unsigned MonthOffset [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };
  localparam int unsigned MonthLength [13] = '{
    0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  dds_pkg::dds_in_t   item_i = '0;
  dds_pkg::dds_out_t  result_o;
  logic               done_o;

  // Stimulus still to be sent, and results still owed by the pipeline.
  dds_pkg::dds_in_t   pair_queue [$];
  dds_pkg::dds_out_t  awaited_durations [$];

  int unsigned sender_gap_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  datetime_difference_seconds_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .result_o (result_o),
    .done_o   (done_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Calendar computation
  // --------------------------------------------------------------------------

  function automatic bit leap_year(input bit [63:0] y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // Seconds since the start of year zero on the proleptic Gregorian calendar.
  // Fields are taken at their raw width and never range-checked, so
  // oversized days, hours, minutes and seconds simply add on linearly.
  function automatic bit [63:0] seconds_since_epoch(input dds_pkg::dds_time_t t);
    bit [63:0] y;
    bit [63:0] days;
    y = 64'(t.year);
    days = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    days += MonthOffset[t.month];
    if (t.month > 2 && leap_year(y)) begin
      days += 1;
    end
    days += t.day;
    return days * 86400 + t.hour * 3600 + t.minute * 60 + t.second;
  endfunction

  function automatic dds_pkg::dds_out_t predict_difference(input dds_pkg::dds_in_t pair);
    dds_pkg::dds_time_t from_t;
    dds_pkg::dds_time_t to_t;
    bit [63:0]          from_s;
    bit [63:0]          to_s;
    dds_pkg::dds_out_t  res;
    from_t = pair[$bits(dds_pkg::dds_in_t)-1 -: TimeW];
    to_t   = pair[TimeW-1:0];
    from_s = seconds_since_epoch(from_t);
    to_s   = seconds_since_epoch(to_t);
    if (from_s > to_s) begin
      res.duration_seconds = '0;
      res.start_is_later   = 1'b1;
    end else begin
      res.duration_seconds = dds_pkg::DurW'(to_s - from_s);
      res.start_is_later   = 1'b0;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic dds_pkg::dds_time_t mk_time(input int y, mo, d, h, mi, s);
    dds_pkg::dds_time_t t;
    t.year = dds_pkg::YearW'(y);
    t.month = dds_pkg::MonthW'(mo);
    t.day = dds_pkg::DayW'(d);
    t.hour = dds_pkg::HourW'(h);
    t.minute = dds_pkg::MinuteW'(mi);
    t.second = dds_pkg::SecondW'(s);
    return t;
  endfunction

  // A well-formed date-time. The years stay in the nominal range; the days
  // respect the length of the month, including leap Februaries.
  function automatic dds_pkg::dds_time_t random_time();
    dds_pkg::dds_time_t t;
    int unsigned last_day;
    t.year = dds_pkg::YearW'($urandom_range(1, 9999));
    t.month = dds_pkg::MonthW'($urandom_range(1, 12));
    last_day = MonthLength[t.month];
    if (t.month == 2 && leap_year(64'(t.year))) begin
      last_day = 29;
    end
    t.day = dds_pkg::DayW'($urandom_range(1, last_day));
    t.hour = dds_pkg::HourW'($urandom_range(0, 23));
    t.minute = dds_pkg::MinuteW'($urandom_range(0, 59));
    t.second = dds_pkg::SecondW'($urandom_range(0, 59));
    return t;
  endfunction

  // Builds one random pair. Most pairs are valid dates: far apart, close
  // together with a few fields moved (so that the start can be later in any
  // single field), or identical. The rest are raw bit noise on every field.
  function automatic dds_pkg::dds_in_t random_pair();
    dds_pkg::dds_time_t a;
    dds_pkg::dds_time_t b;
    dds_pkg::dds_time_t fresh;
    int unsigned kind;
    int unsigned moves;
    kind = $urandom_range(0, 99);
    a = random_time();
    b = random_time();
    if (kind >= 35 && kind < 70) begin
      // Neighbors: copy, then move one to three fields to values drawn anew.
      b = a;
      moves = $urandom_range(1, 3);
      repeat (moves) begin
        fresh = random_time();
        case ($urandom_range(0, 5))
          0: b.year = ($urandom_range(0, 1) != 0) ? a.year + 14'd1 : fresh.year;
          1: b.month = fresh.month;
          2: b.day = fresh.day;
          3: b.hour = fresh.hour;
          4: b.minute = fresh.minute;
          default: b.second = fresh.second;
        endcase
      end
      if ($urandom_range(0, 1) != 0) begin
        fresh = a;
        a = b;
        b = fresh;
      end
    end else if (kind >= 70 && kind < 80) begin
      b = a;
    end else if (kind >= 80) begin
      a = TimeW'({$urandom, $urandom});
      b = TimeW'({$urandom, $urandom});
    end
    return {a, b};
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] error: %s got %0d, wanted %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the next pending pair whenever the current one has been
  // taken or none is on the bus. The gap rate decides idle cycles. Only one
  // nonblocking assignment per signal is made in each clock step.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
    end else if (!start || !busy) begin
      if (pair_queue.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        start <= 1'b1;
        item_i <= pair_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks the result beat of this edge against the oldest owed
  // result, then records the expectation for an input beat taken at this
  // edge. Both happen in one block so their order is fixed. It also runs the
  // quiet-cycle watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    dds_pkg::dds_out_t want;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (done_o) begin
        if (awaited_durations.size() == 0) begin
          report_mismatch("unexpected result, duration_seconds",
                          result_o.duration_seconds, 0);
        end else begin
          want = awaited_durations.pop_front();
          if (result_o.duration_seconds !== want.duration_seconds) begin
            report_mismatch("duration_seconds", result_o.duration_seconds,
                            want.duration_seconds);
          end
          if (result_o.start_is_later !== want.start_is_later) begin
            report_mismatch("start_is_later", result_o.start_is_later,
                            want.start_is_later);
          end
        end
      end
      if (start && !busy) begin
        awaited_durations.push_back(predict_difference(item_i));
      end
      if (done_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: reset, directed pairs, then the three random phases. All
  // changes to shared variables happen on the falling edge so the clocked
  // blocks never race with them.
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pairs, sent back to back.
    sender_gap_pct = 0;
    // Equal times on a leap day.
    pair_queue.push_back({mk_time(2024, 2, 29, 12, 34, 56), mk_time(2024, 2, 29, 12, 34, 56)});
    // Start one second after the end.
    pair_queue.push_back({mk_time(2024, 2, 29, 12, 34, 57), mk_time(2024, 2, 29, 12, 34, 56)});
    // Start later by month only; the end has the larger day and time.
    pair_queue.push_back({mk_time(2020, 3, 1, 0, 0, 0), mk_time(2020, 2, 29, 23, 59, 59)});
    // Start later by hour only; the end has the larger minute.
    pair_queue.push_back({mk_time(1999, 7, 4, 10, 0, 0), mk_time(1999, 7, 4, 9, 59, 59)});
    // Whole nominal range and its reverse.
    pair_queue.push_back({mk_time(1, 1, 1, 0, 0, 0), mk_time(9999, 12, 31, 23, 59, 59)});
    pair_queue.push_back({mk_time(9999, 12, 31, 23, 59, 59), mk_time(1, 1, 1, 0, 0, 0)});
    // Every field at zero against every field at all ones, then all ones against itself.
    pair_queue.push_back({mk_time(0, 0, 0, 0, 0, 0), mk_time(16383, 15, 31, 31, 63, 63)});
    pair_queue.push_back({mk_time(16383, 15, 31, 31, 63, 63), mk_time(16383, 15, 31, 31, 63, 63)});
    // Month zero lands on January.
    pair_queue.push_back({mk_time(2010, 0, 5, 1, 2, 3), mk_time(2010, 1, 5, 1, 2, 3)});
    // Months past December land on the first day of the next year.
    pair_queue.push_back({mk_time(2023, 13, 1, 0, 0, 0), mk_time(2024, 1, 1, 0, 0, 0)});
    pair_queue.push_back({mk_time(2024, 15, 1, 0, 0, 0), mk_time(2025, 1, 1, 0, 0, 0)});
    // Day zero is the last day of the previous month.
    pair_queue.push_back({mk_time(2021, 3, 0, 8, 0, 0), mk_time(2021, 2, 28, 8, 0, 0)});
    // Century rules: 1900 and 2100 are common, 2000 is leap.
    pair_queue.push_back({mk_time(1900, 2, 28, 0, 0, 0), mk_time(1900, 3, 1, 0, 0, 0)});
    pair_queue.push_back({mk_time(2000, 2, 28, 0, 0, 0), mk_time(2000, 3, 1, 0, 0, 0)});
    pair_queue.push_back({mk_time(2100, 2, 28, 0, 0, 0), mk_time(2100, 3, 1, 0, 0, 0)});
    // Year zero is a leap year.
    pair_queue.push_back({mk_time(0, 2, 28, 0, 0, 0), mk_time(0, 3, 1, 0, 0, 0)});
    // Whole years skipped across a leap February.
    pair_queue.push_back({mk_time(2003, 3, 1, 0, 0, 0), mk_time(2005, 3, 1, 0, 0, 0)});
    // Oversized hour, minute and second run on into the next day.
    pair_queue.push_back({mk_time(2022, 6, 15, 31, 63, 63), mk_time(2022, 6, 16, 8, 4, 3)});
    // Day 31 in a thirty-day month, and crossing past year 9999.
    pair_queue.push_back({mk_time(2019, 4, 31, 0, 0, 0), mk_time(2019, 5, 1, 0, 0, 0)});
    pair_queue.push_back({mk_time(9999, 12, 31, 23, 59, 59), mk_time(10000, 1, 1, 0, 0, 0)});

    // Hold off until the pipeline has returned every owed result.
    while (pair_queue.size() != 0 || start || awaited_durations.size() != 0) begin
      @(negedge clk_i);
    end

    // Random phases: light gaps, heavy gaps, then no gaps at all.
    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct = (phase == 0) ? 12 : (phase == 1) ? 84 : 0;
      for (int n = 0; n < RandomPerPhase; n++) begin
        pair_queue.push_back(random_pair());
      end
      while (pair_queue.size() != 0 || start) begin
        @(negedge clk_i);
      end
    end

    // Drain: wait for the last owed result, then a few pipeline depths more
    // so that any stray extra beat would still be caught.
    while (awaited_durations.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (10) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
